// ===== rtl/core/fsi_pkg.sv =====
// ----------------------------------------------------------------------------
// fsi_pkg
// Shared types, constants and the grade table generator for the zero-order
// Sugeno fuzzy inference block.
// ----------------------------------------------------------------------------
package fsi_pkg;

  // Default sizing
  localparam int MAX_RULES_DEF  = 14;
  localparam int GRADE_FRAC_DEF = 16;

  // Gaussian width: mu(d) = exp(-d*d / (GAUSS_SCALE * SIGMA * SIGMA))
  localparam int SIGMA       = 30;
  localparam int GAUSS_SCALE = 2;
  localparam int GAUSS_DIV   = GAUSS_SCALE * SIGMA * SIGMA;

  // Grade table depth, indexed by |d|
  localparam int TAB_DEPTH = 256;
  localparam int TAB_IDX_W = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 50;
  localparam int COUNT_W     = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAIR_BASE  = 3'd1;

  // Rule word layout
  localparam int RULE_W     = 25;
  localparam int RULE_CE_LO = 0;
  localparam int RULE_OP    = 8;
  localparam int RULE_CD_LO = 9;
  localparam int RULE_Z_LO  = 17;

  // Quotient width of the Q8.8 result magnitude
  localparam int QBITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRADE_E,
    ST_GRADE_D,
    ST_ACCUM,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } fsi_state_t;

  // Unsigned 64-bit floor quotient by shift and subtract
  function automatic longint unsigned div_u64(longint unsigned dividend,
                                              longint unsigned divisor);
    longint unsigned quot;
    longint unsigned part;
    quot = '0;
    part = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[62:0], dividend[b]};
      if (part >= divisor) begin
        part    = part - divisor;
        quot[b] = 1'b1;
      end
    end
    return quot;
  endfunction

  // exp(-t) in Q2.30 by a Taylor series through the t^24 term, clamped at zero
  function automatic longint unsigned exp_neg_q30(longint unsigned t);
    longint unsigned term;
    longint          sum;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (longint unsigned i = 1; i <= 24; i++) begin
      term = div_u64((term * t) >> 30, i);
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return longint'(sum);
  endfunction

  // One grade table entry in Q0.frac, rounded and saturated
  function automatic logic [31:0] grade_entry(int d, int frac);
    longint unsigned k;
    longint unsigned n;
    longint unsigned r;
    longint unsigned v;
    longint unsigned e1;
    longint unsigned g;
    longint unsigned lim;
    k   = longint'(d) * longint'(d);
    n   = div_u64(k, 64'(GAUSS_DIV));
    r   = k - n * 64'(GAUSS_DIV);
    e1  = exp_neg_q30(64'd1 << 30);
    v   = exp_neg_q30(div_u64(r << 30, 64'(GAUSS_DIV)));
    lim = (64'd1 << frac) - 64'd1;
    while (n > 0 && v != 0) begin
      v = (v * e1) >> 30;
      n = n - 1;
    end
    g = ((v << frac) + (64'd1 << 29)) >> 30;
    if (g > lim) begin
      g = lim;
    end
    return g[31:0];
  endfunction

endpackage

// ===== rtl/core/fuzzy_sugeno_inference_top.sv =====
// ----------------------------------------------------------------------------
// fuzzy_sugeno_inference_top
// Zero-order Sugeno fuzzy controller: grades error and error change against
// each active rule with a Gaussian table, combines by min or max, and gives
// the strength-weighted average of the rule outputs in signed Q8.8.
// ----------------------------------------------------------------------------
//  channel   direction  fields (low bit first)
//  s_axis    in         tdata: error_value[7:0], error_change[15:8]
//  m_axis    out        tdata: drive_value[15:0]; tuser: no_match[0]
//  cfg       in         cfg_index selects rule_count (0) or rule_pair_0..6
//
//  Each word steps through the error grade, change grade and accumulate
//  states once per active rule, through the shared grade lookup and
//  multiply-accumulate, then through the bit-serial divider.
//  With zero total strength the divider is skipped, and with no active
//  rules the word goes straight to the result.
//  Input is accepted only when idle; a finished result waits in the output
//  register, and the next word is taken while it waits.
//  rst is synchronous and clears control state and the rule registers.
// ----------------------------------------------------------------------------
module fuzzy_sugeno_inference_top #(
  parameter int MAX_RULES       = fsi_pkg::MAX_RULES_DEF,
  parameter int GRADE_FRAC_BITS = fsi_pkg::GRADE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,   // error_value, error_change
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // drive_value
  output logic [0:0]                     m_axis_tuser,   // no_match
  // configuration
  input  logic                           cfg_we,
  input  logic [fsi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fsi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fsi_pkg::*;

  localparam int GW      = GRADE_FRAC_BITS;
  localparam int PAIRS   = (MAX_RULES + 1) / 2;
  localparam int PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int RIDX_W  = $clog2(MAX_RULES + 1);
  localparam int PROD_W  = GW + 9;
  localparam int NUM_W   = GW + 13;
  localparam int DEN_W   = GW + 4;
  localparam int R_W     = NUM_W + 8;
  localparam int QCNT_W  = $clog2(QBITS);

  // Grade table, computed at elaboration
  logic [GW-1:0] grade_rom [TAB_DEPTH];
  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    localparam logic [31:0] ENTRY = grade_entry(g, GRADE_FRAC_BITS);
    assign grade_rom[g] = ENTRY[GW-1:0];
  end

  // Configuration registers
  logic [COUNT_W-1:0]    rule_count;
  logic [CFG_DATA_W-1:0] rule_pair [PAIRS];
  logic [CFG_INDEX_W-1:0] pair_wsel;

  assign pair_wsel = cfg_index - REG_PAIR_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      for (int p = 0; p < PAIRS; p++) begin
        rule_pair[p] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_RULE_COUNT) begin
        rule_count <= cfg_data[COUNT_W-1:0];
      end else if (32'(pair_wsel) < PAIRS) begin
        rule_pair[PAIR_W'(pair_wsel)] <= cfg_data;
      end
    end
  end

  // Active rule count, clamped to the rule storage
  logic [RIDX_W-1:0] n_rules;
  assign n_rules = (rule_count > COUNT_W'(MAX_RULES)) ? RIDX_W'(MAX_RULES)
                                                      : RIDX_W'(rule_count);

  // State and datapath registers
  fsi_state_t              state, state_next;
  logic [RIDX_W-1:0]       ridx;
  logic signed [7:0]       err;
  logic signed [7:0]       derr;
  logic [GW-1:0]           ge;
  logic [GW-1:0]           alpha;
  logic signed [7:0]       zval;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic [R_W-1:0]          rem;
  logic [R_W-1:0]          dsh;
  logic [QBITS-1:0]        quo;
  logic [QCNT_W-1:0]       qcnt;
  logic                    neg;

  // Control decode
  logic use_delta;
  logic load_out;
  logic last_rule;

  assign last_rule = (RIDX_W'(ridx + 1'b1) == n_rules);

  // Current rule fields
  logic [CFG_DATA_W-1:0] pair_word;
  logic [RULE_W-1:0]     rule_word;
  logic signed [7:0]     rule_ce;
  logic signed [7:0]     rule_cd;
  logic signed [7:0]     rule_z;
  logic                  rule_or;

  assign pair_word = rule_pair[PAIR_W'(ridx >> 1)];
  assign rule_word = ridx[0] ? pair_word[2*RULE_W-1:RULE_W] : pair_word[RULE_W-1:0];
  assign rule_ce   = rule_word[RULE_CE_LO +: 8];
  assign rule_cd   = rule_word[RULE_CD_LO +: 8];
  assign rule_z    = rule_word[RULE_Z_LO +: 8];
  assign rule_or   = rule_word[RULE_OP];

  // Shared grade unit: |x - c| into the table
  logic signed [7:0] g_x;
  logic signed [7:0] g_c;
  logic signed [8:0] g_diff;
  logic [8:0]        g_abs;
  logic [GW-1:0]     g_cur;
  logic [GW-1:0]     g_comb;

  assign g_x    = use_delta ? derr : err;
  assign g_c    = use_delta ? rule_cd : rule_ce;
  assign g_diff = 9'({g_x[7], g_x}) - 9'({g_c[7], g_c});
  assign g_abs  = g_diff[8] ? 9'(-g_diff) : 9'(g_diff);
  assign g_cur  = grade_rom[g_abs[TAB_IDX_W-1:0]];
  assign g_comb = rule_or ? ((ge > g_cur) ? ge : g_cur)
                          : ((ge < g_cur) ? ge : g_cur);

  // Multiply-accumulate operand
  logic signed [PROD_W-1:0] prod;
  assign prod = $signed({1'b0, alpha}) * zval;

  // Divider step and result shaping
  logic [NUM_W-1:0]  num_mag;
  logic              rem_ge;
  logic [QBITS-1:0]  drive;
  logic [QBITS:0]    quo_neg;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rem_ge  = (rem >= dsh);
  assign quo_neg = (QBITS+1)'(-{1'b0, quo});
  assign drive   = neg ? quo_neg[QBITS-1:0]
                       : (quo[QBITS-1] ? {1'b0, {(QBITS-1){1'b1}}} : quo);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (n_rules == '0) ? ST_FINISH : ST_GRADE_E;
        end
      end
      ST_GRADE_E: state_next = ST_GRADE_D;
      ST_GRADE_D: state_next = ST_ACCUM;
      ST_ACCUM:   state_next = last_rule ? ST_PREP : ST_GRADE_E;
      ST_PREP:    state_next = (den == '0) ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: begin
        if (qcnt == QCNT_W'(QBITS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    use_delta     = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_GRADE_D: use_delta     = 1'b1;
      ST_FINISH:  load_out      = !m_axis_tvalid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        err  <= s_axis_tdata[7:0];
        derr <= s_axis_tdata[15:8];
        ridx <= '0;
        num  <= '0;
        den  <= '0;
      end
      // grade the error against the rule's error center
      ST_GRADE_E: ge <= g_cur;
      // grade the change and combine into the rule strength
      ST_GRADE_D: begin
        alpha <= g_comb;
        zval  <= rule_z;
      end
      // accumulate weighted output and total strength
      ST_ACCUM: begin
        num  <= num + NUM_W'(prod);
        den  <= den + DEN_W'(alpha);
        ridx <= RIDX_W'(ridx + 1'b1);
      end
      // load the divider with |num|*256 and den aligned to the top quotient bit
      ST_PREP: begin
        rem  <= R_W'({num_mag, 8'b0});
        dsh  <= R_W'({den, {(QBITS-1){1'b0}}});
        quo  <= '0;
        qcnt <= '0;
        neg  <= num[NUM_W-1];
      end
      // one restoring quotient bit per cycle
      ST_DIVIDE: begin
        if (rem_ge) begin
          rem <= rem - dsh;
        end
        quo  <= {quo[QBITS-2:0], rem_ge};
        dsh  <= dsh >> 1;
        qcnt <= QCNT_W'(qcnt + 1'b1);
      end
      default: begin
        ridx <= ridx;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata    <= (den == '0) ? '0 : drive;
      m_axis_tuser[0] <= (den == '0);
    end
  end

  // Checks
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("no_match result with nonzero drive");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && den != '0 |-> rem < R_W'(den))
    else $error("divider remainder not below divisor");

  a_ridx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_GRADE_E |-> ridx < n_rules)
    else $error("rule index past active rule count");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != ST_IDLE)
    else $error("accepted word left block idle");

endmodule

// ===== dv/drive_checker.sv =====
// ----------------------------------------------------------------------------
// drive_checker
// Watches the rule writes and both stream channels of the fuzzy inference
// block. Keeps its own copy of the rule set and the Gaussian grade table,
// predicts drive_value and no_match for every accepted word, and compares
// each result word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module drive_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // error_value, error_change
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,   // drive_value
  input  logic [0:0]                      m_axis_tuser,   // no_match
  input  logic                            cfg_we,
  input  logic [fsi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fsi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fsi_pkg::*;

  localparam int RULE_LIMIT = MAX_RULES_DEF;
  localparam int FRAC       = GRADE_FRAC_DEF;
  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [15:0] drive;
    logic        no_match;
  } drive_t;

  logic [COUNT_W-1:0]    rule_cnt = '0;
  logic [CFG_DATA_W-1:0] rule_pairs [7];
  int                    grade_lut [TAB_DEPTH];
  drive_t                expected_drives [$];
  int                    errors = 0;

  // Taylor series of exp(-t), Q2.30, floored terms, clamped at zero
  function automatic longint unsigned decay_q30(longint unsigned t);
    longint unsigned term;
    longint          acc;
    longint unsigned k;
    term = UNIT_Q30;
    acc  = longint'(UNIT_Q30);
    for (k = 1; k <= 24; k++) begin
      term = ((term * t) >> 30) / k;
      acc  = k[0] ? acc - longint'(term) : acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // Build the grade table: whole units of d*d/div by repeated exp(-1)
  initial begin : build_lut
    longint unsigned e_one;
    longint unsigned sq;
    longint unsigned whole;
    longint unsigned v;
    longint unsigned g;
    int              d;
    e_one = decay_q30(UNIT_Q30);
    for (d = 0; d < TAB_DEPTH; d++) begin
      sq    = longint'(d) * longint'(d);
      whole = sq / GAUSS_DIV;
      v     = decay_q30(((sq % GAUSS_DIV) << 30) / GAUSS_DIV);
      while (whole > 0 && v != 0) begin
        v     = (v * e_one) >> 30;
        whole = whole - 1;
      end
      g = ((v << FRAC) + (UNIT_Q30 >> 1)) >> 30;
      if (g > (64'd1 << FRAC) - 1) begin
        g = (64'd1 << FRAC) - 1;
      end
      grade_lut[d] = int'(g);
    end
  end

  // Gaussian grade of a sample against a center
  function automatic int member(logic [7:0] x, logic [7:0] c);
    int span;
    span = int'($signed(x)) - int'($signed(c));
    if (span < 0) begin
      span = -span;
    end
    return grade_lut[span];
  endfunction

  // Strength-weighted average of the active rule outputs, Q8.8
  function automatic drive_t infer_drive(logic [7:0] err, logic [7:0] derr);
    drive_t            res;
    logic [RULE_W-1:0] rule;
    int                active;
    int                i;
    int                ge;
    int                gd;
    int                alpha;
    int                zout;
    longint            num;
    longint            den;
    longint            quo;
    active = (int'(rule_cnt) > RULE_LIMIT) ? RULE_LIMIT : int'(rule_cnt);
    num = 0;
    den = 0;
    for (i = 0; i < active; i++) begin
      rule = rule_pairs[i / 2][(i % 2) * RULE_W +: RULE_W];
      ge   = member(err, rule[RULE_CE_LO +: 8]);
      gd   = member(derr, rule[RULE_CD_LO +: 8]);
      if (rule[RULE_OP]) begin
        alpha = (ge > gd) ? ge : gd;
      end else begin
        alpha = (ge < gd) ? ge : gd;
      end
      zout = int'($signed(rule[RULE_Z_LO +: 8]));
      num  = num + longint'(alpha) * longint'(zout);
      den  = den + longint'(alpha);
    end
    if (den == 0) begin
      res.drive    = '0;
      res.no_match = 1'b1;
    end else begin
      quo = (num * 256) / den;
      if (quo > 32767) begin
        quo = 32767;
      end
      if (quo < -32768) begin
        quo = -32768;
      end
      res.drive    = quo[15:0];
      res.no_match = 1'b0;
    end
    return res;
  endfunction

  // Count a failure, report only the first few
  function automatic void flag(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endfunction

  // Track rule writes, predict on input words, compare on output words
  always @(posedge clk) begin : watch
    drive_t got;
    drive_t want;
    if (rst) begin
      rule_cnt = '0;
      for (int p = 0; p < 7; p++) begin
        rule_pairs[p] = '0;
      end
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RULE_COUNT) begin
          rule_cnt = cfg_data[COUNT_W-1:0];
        end else begin
          rule_pairs[int'(cfg_index) - int'(REG_PAIR_BASE)] = cfg_data;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive    = m_axis_tdata;
        got.no_match = m_axis_tuser[0];
        if (expected_drives.size() == 0) begin
          flag($sformatf("unexpected word: drive %h no_match %b",
                         got.drive, got.no_match));
        end else begin
          want = expected_drives.pop_front();
          if (got.drive !== want.drive || got.no_match !== want.no_match) begin
            flag($sformatf("mismatch: drive exp %h got %h, no_match exp %b got %b",
                           want.drive, got.drive, want.no_match, got.no_match));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_drives.push_back(infer_drive(s_axis_tdata[7:0], s_axis_tdata[15:8]));
      end
    end
    pending    <= expected_drives.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fuzzy inference block: directed rule sets at the field
// extremes, then random rule sets with words aimed near the rule centers,
// with random idling on both stream sides. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsi_pkg::*;

  localparam logic OP_AND = 1'b0;
  localparam logic OP_OR  = 1'b1;
  localparam int   RANDOM_PHASES = 10;
  localparam int   PHASE_WORDS   = 75;
  localparam int   SETTLE_CYCLES = 80;
  localparam longint TIMEOUT_NS  = 64'd6_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          fail_count;
  int          pending;
  logic        quiet = 1'b0;
  int          stall_left = 0;
  logic [RULE_W-1:0] rule_set [14];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fuzzy_sugeno_inference_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  drive_checker drive_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Idle length: mostly none or short, a few long
  function automatic int bubble_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) begin
      return 0;
    end else if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RULE_W-1:0] pack_rule(logic [7:0] ce, logic op,
                                                  logic [7:0] cd, logic [7:0] z);
    return {z, cd, op, ce};
  endfunction

  // Sample within +-20 of a center, kept in the signed 8-bit range
  function automatic logic [7:0] near(logic [7:0] c);
    int v;
    v = int'($signed(c)) + $urandom_range(0, 40) - 20;
    if (v > 127) begin
      v = 127;
    end
    if (v < -128) begin
      v = -128;
    end
    return v[7:0];
  endfunction

  // Output side: random stalls unless in a quiet stretch
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= bubble_len();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one word after a random gap, hold until taken
  task automatic send_word(input logic [7:0] err, input logic [7:0] derr);
    int gap;
    gap = bubble_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {derr, err};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every predicted word to come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write the count word and all seven rule pairs
  task automatic apply_rules(input logic [CFG_DATA_W-1:0] count_word);
    logic [2:0] p;
    write_reg(REG_RULE_COUNT, count_word);
    for (int k = 0; k < 7; k++) begin
      p = k[2:0];
      write_reg(REG_PAIR_BASE + p, {rule_set[2 * k + 1], rule_set[2 * k]});
    end
    cfg_we <= 1'b0;
  endtask

  // Limit on the whole run
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int                    phase;
    int                    n;
    int                    cnt;
    int                    act;
    int                    pick;
    logic [CFG_DATA_W-1:0] cw;
    logic [7:0]            ea;
    logic [7:0]            eb;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // No rules after reset: zero strength
    send_word(8'h00, 8'h00);
    send_word(8'h7f, 8'h80);

    // Strong AND rule at the low corner, OR rule at the high corner
    drain();
    for (n = 0; n < 14; n++) begin
      rule_set[n] = '0;
    end
    rule_set[0] = pack_rule(8'h80, OP_AND, 8'h80, 8'h80);
    rule_set[1] = pack_rule(8'h7f, OP_OR, 8'h7f, 8'h7f);
    apply_rules(50'd2);
    send_word(8'h80, 8'h80);
    send_word(8'h7f, 8'h7f);
    send_word(8'h80, 8'h7f);
    send_word(8'h7f, 8'h80);
    send_word(8'h00, 8'h00);
    send_word(8'hff, 8'h01);

    // One AND rule with opposite centers; junk above the count field
    drain();
    rule_set[0] = pack_rule(8'h80, OP_AND, 8'h7f, 8'h55);
    rule_set[1] = '0;
    apply_rules(50'h3_ffff_ffff_fff1);
    send_word(8'h7f, 8'h80);
    send_word(8'h80, 8'h7f);

    // Count above the rule limit, spread centers and mixed ops
    drain();
    for (n = 0; n < 14; n++) begin
      ea = 8'(n * 18 - 128);
      eb = 8'(127 - n * 18);
      rule_set[n] = pack_rule(ea, n[0], eb, (n < 7) ? 8'h80 : 8'h7f);
    end
    apply_rules(50'd15);
    send_word(8'h80, 8'h7f);
    send_word(8'h7f, 8'h80);
    send_word(8'h00, 8'h00);
    send_word(8'h80, 8'h80);
    send_word(8'h7f, 8'h7f);
    send_word(8'h40, 8'hc0);

    // All fourteen OR rules at the origin, highest output
    drain();
    for (n = 0; n < 14; n++) begin
      rule_set[n] = pack_rule(8'h00, OP_OR, 8'h00, 8'h7f);
    end
    apply_rules(50'd14);
    send_word(8'h00, 8'h00);
    send_word(8'h7f, 8'h00);
    send_word(8'h80, 8'h80);
    send_word(8'h2a, 8'hd6);

    // Random rule sets, words mostly aimed near active centers
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      quiet <= (phase % 4 == 3);
      for (n = 0; n < 14; n++) begin
        rule_set[n] = pack_rule(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      case (phase)
        0: begin
          cnt = 14;
        end
        1: begin
          cnt = 15;
        end
        2: begin
          cnt = 0;
        end
        3: begin
          cnt = 1;
        end
        default: begin
          cnt = $urandom_range(1, 15);
        end
      endcase
      cw = CFG_DATA_W'({$urandom(), $urandom()});
      cw[COUNT_W-1:0] = cnt[COUNT_W-1:0];
      apply_rules(cw);
      act = (cnt > MAX_RULES_DEF) ? MAX_RULES_DEF : cnt;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (act != 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, act - 1);
          ea   = near(rule_set[pick][RULE_CE_LO +: 8]);
          eb   = near(rule_set[pick][RULE_CD_LO +: 8]);
        end else begin
          ea = 8'($urandom_range(0, 255));
          eb = 8'($urandom_range(0, 255));
        end
        send_word(ea, eb);
      end
    end

    // Wait out the last results, then the block's latency
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
